@@ rtl/core/piecewise_bezier_evaluator_defines.svh @@
// Assertion macros for the piecewise Bezier evaluator.
`ifndef PIECEWISE_BEZIER_EVALUATOR_DEFINES_SVH
`define PIECEWISE_BEZIER_EVALUATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PBE_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("pbe check failed");
`define PBE_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbe check failed");
`define PBE_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbe check failed");
`else
`define PBE_ASSERT(lbl, cond)
`define PBE_IMPLY(lbl, ante, cons)
`define PBE_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/core/pbe_pkg.sv @@
// Shared types, constants and helpers of the Bezier evaluator.
package pbe_pkg;
    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int COORD_W    = 16;
    localparam int ACC_W      = 32;
    localparam int PROD_W     = 49;
    localparam int FRAC_W     = 12;
    localparam int ENTRY_W    = 3 * COORD_W;

    typedef enum logic [1:0] {
        OP_WRITE    = 2'd0,
        OP_EVAL_X   = 2'd1,
        OP_EVAL_SEG = 2'd2,
        OP_NONE     = 2'd3
    } opcode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_LAST,
        S_SCAN0,
        S_SCAN1,
        S_DIV,
        S_LOAD_RD,
        S_LOAD_WR,
        S_MUL,
        S_ADD
    } state_t;

    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   addr;
        logic [ENTRY_W-1:0] data;
    } tbl_wr_t;

    function automatic logic signed [COORD_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > 32'sd32767)
            r = 16'sh7FFF;
        else if (v < -32'sd32768)
            r = 16'sh8000;
        else
            r = v[COORD_W-1:0];
        return r;
    endfunction
endpackage

@@ rtl/core/pbe_table.sv @@
// Control point memory: one write port, one registered read port.
module pbe_table
    import pbe_pkg::*;
(
    input  logic               clk,
    input  tbl_wr_t            wr,
    input  logic [IDX_W-1:0]   rd_addr,
    output logic [ENTRY_W-1:0] rd_data
);
    logic [ENTRY_W-1:0] mem [MAX_POINTS];
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr] <= wr.data;
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

@@ rtl/core/pbe_div.sv @@
// Radix-2 restoring divider for the local parameter, quotient at most 1.0 in Q1.12.
module pbe_div
    import pbe_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [16:0]   num,
    input  logic [16:0]   den,
    output logic          done,
    output logic [12:0]   quo
);
    logic [17:0] rem_reg, rem_next;
    logic [16:0] den_reg, den_next;
    logic [12:0] quo_reg, quo_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [17:0] trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = (cnt_reg == 4'd0) ? rem_reg : {rem_reg[16:0], 1'b0};
        if (start)
        begin
            rem_next = {1'b0, num};
            den_next = den;
            quo_next = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[11:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[11:0], 1'b0};
            end
            if (cnt_reg == 4'd12)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
                cnt_next = cnt_reg + 4'd1;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
endmodule

@@ rtl/core/piecewise_bezier_evaluator.sv @@
// Piecewise Bezier evaluator: Q4.12 control point table, x lookup and de Casteljau.
// A write or idle op finishes in the decode state; an evaluation runs the x scan (x lookup
//   only), the divide, the point loads and then the multiply and add steps in turn.
// One request at a time; busy is high until the result strobe, which lasts one cycle.
// Rate set by the single read port of the point memory and the shared interpolator.
// Reset (rst_n async low): degree 3, count 0, idle; table contents undefined until written.
`include "piecewise_bezier_evaluator_defines.svh"
module piecewise_bezier_evaluator
    import pbe_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                opcode,
    input  logic [5:0]                slot,
    input  logic signed [15:0]        coord_x,
    input  logic signed [15:0]        coord_y,
    input  logic signed [15:0]        coord_z,
    input  logic signed [15:0]        param_t,
    output logic                      done,
    output logic signed [15:0]        point_x,
    output logic signed [15:0]        point_y,
    output logic signed [15:0]        point_z,
    output logic                      fell_back
);
    // configuration registers
    logic [1:0]       cfg_deg_reg;
    logic [CNT_W-1:0] cfg_cnt_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = paddr[2] ? {25'd0, cfg_cnt_reg} : {30'd0, cfg_deg_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_deg_reg <= 2'd3;
            cfg_cnt_reg <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2])
                cfg_cnt_reg <= pwdata[CNT_W-1:0];
            else
                cfg_deg_reg <= pwdata[1:0];
        end
    end

    // control and datapath registers
    state_t                    state_reg, state_next;
    logic [1:0]                op_reg, op_next;
    logic [IDX_W-1:0]          slot_reg, slot_next;
    logic signed [15:0]        t_reg, t_next;
    logic [ENTRY_W-1:0]        wdat_reg, wdat_next;
    logic [1:0]                deg_reg, deg_next;
    logic [CNT_W-1:0]          n_reg, n_next;
    logic [CNT_W-1:0]          scan_reg, scan_next;
    logic signed [15:0]        x0_reg, x0_next;
    logic [7:0]                base_reg, base_next;
    logic signed [15:0]        u_reg, u_next;
    logic [1:0]                k_reg, k_next;
    logic [1:0]                lvl_reg, lvl_next;
    logic [1:0]                idx_reg, idx_next;
    logic signed [ACC_W-1:0]   p_reg [3][4];
    logic signed [ACC_W-1:0]   p_next [3][4];
    logic signed [PROD_W-1:0]  prod_reg [3];
    logic signed [PROD_W-1:0]  prod_next [3];
    logic signed [15:0]        ox_reg, ox_next, oy_reg, oy_next, oz_reg, oz_next;
    logic                      fell_reg, fell_next;
    logic                      done_reg, done_next;

    // memory and divider hookup
    tbl_wr_t            tbl_wr;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic               div_start, div_done;
    logic [16:0]        div_num, div_den;
    logic [12:0]        div_quo;

    pbe_table u_table (
        .clk     (clk),
        .wr      (tbl_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pbe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        slot_reg <= slot_next;
        t_reg    <= t_next;
        wdat_reg <= wdat_next;
        deg_reg  <= deg_next;
        n_reg    <= n_next;
        scan_reg <= scan_next;
        x0_reg   <= x0_next;
        base_reg <= base_next;
        u_reg    <= u_next;
        k_reg    <= k_next;
        lvl_reg  <= lvl_next;
        idx_reg  <= idx_next;
        p_reg    <= p_next;
        prod_reg <= prod_next;
        ox_reg   <= ox_next;
        oy_reg   <= oy_next;
        oz_reg   <= oz_next;
        fell_reg <= fell_next;
    end

    logic signed [15:0]      rd_x, rd_y, rd_z;
    logic [1:0]              idx_p1;
    logic signed [ACC_W:0]   diff [3];
    logic signed [ACC_W-1:0] sum [3];
    logic [7:0]              seg_base, scan_nx, deg8, n8;
    logic                    bracket;

    assign rd_x   = rd_data[47:32];
    assign rd_y   = rd_data[31:16];
    assign rd_z   = rd_data[15:0];
    assign idx_p1 = idx_reg + 2'd1;
    assign deg8   = {6'd0, deg_reg};
    assign n8     = {1'b0, n_reg};

    // interpolation lanes x, y, z: product then round-half-up and accumulate
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            diff[c] = {p_reg[c][idx_p1][ACC_W-1], p_reg[c][idx_p1]}
                    - {p_reg[c][idx_reg][ACC_W-1], p_reg[c][idx_reg]};
            sum[c]  = p_reg[c][idx_reg] + ACC_W'((prod_reg[c] + PROD_W'(2048)) >>> FRAC_W);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        slot_next  = slot_reg;
        t_next     = t_reg;
        wdat_next  = wdat_reg;
        deg_next   = deg_reg;
        n_next     = n_reg;
        scan_next  = scan_reg;
        x0_next    = x0_reg;
        base_next  = base_reg;
        u_next     = u_reg;
        k_next     = k_reg;
        lvl_next   = lvl_reg;
        idx_next   = idx_reg;
        p_next     = p_reg;
        prod_next  = prod_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        oz_next    = oz_reg;
        fell_next  = fell_reg;
        done_next  = 1'b0;
        tbl_wr     = '0;
        rd_addr    = '0;
        div_start  = 1'b0;
        div_num    = 17'({t_reg[15], t_reg} - {x0_reg[15], x0_reg});
        div_den    = 17'({rd_x[15], rd_x} - {x0_reg[15], x0_reg});
        seg_base   = {6'd0, deg_reg} * {2'd0, slot_reg};
        scan_nx    = {1'b0, scan_reg} + deg8;
        bracket    = (x0_reg <= t_reg) && (rd_x >= t_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = opcode;
                    slot_next  = slot;
                    t_next     = param_t;
                    wdat_next  = {coord_x, coord_y, coord_z};
                    deg_next   = (cfg_deg_reg == 2'd0) ? 2'd1 : cfg_deg_reg;
                    n_next     = (cfg_cnt_reg > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                                   : cfg_cnt_reg;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                ox_next   = '0;
                oy_next   = '0;
                oz_next   = '0;
                fell_next = 1'b0;
                if (op_reg == OP_WRITE || op_reg == OP_NONE)
                begin
                    tbl_wr.en   = (op_reg == OP_WRITE);
                    tbl_wr.addr = slot_reg;
                    tbl_wr.data = wdat_reg;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (n8 < deg8 + 8'd1)
                begin
                    // too few points: last point, or zero on an empty table
                    rd_addr = IDX_W'(n_reg - CNT_W'(1));
                    if (n_reg == '0)
                    begin
                        fell_next  = 1'b1;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                        state_next = S_LAST;
                end
                else if (op_reg == OP_EVAL_X)
                begin
                    rd_addr    = '0;
                    scan_next  = '0;
                    state_next = S_SCAN0;
                end
                else if ({1'b0, seg_base} + {7'd0, deg_reg} >= {2'b0, n_reg})
                begin
                    rd_addr    = IDX_W'(n_reg - CNT_W'(1));
                    state_next = S_LAST;
                end
                else
                begin
                    base_next  = seg_base;
                    u_next     = t_reg;
                    k_next     = '0;
                    state_next = S_LOAD_RD;
                end
            end
            S_LAST:
            begin
                ox_next    = rd_x;
                oy_next    = rd_y;
                oz_next    = rd_z;
                fell_next  = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_SCAN0:
            begin
                x0_next    = rd_x;
                rd_addr    = IDX_W'(scan_nx);
                state_next = S_SCAN1;
            end
            S_SCAN1:
            begin
                if (bracket)
                begin
                    base_next = {1'b0, scan_reg};
                    k_next    = '0;
                    if (rd_x != x0_reg)
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        // zero-width segment evaluates at its start
                        u_next     = '0;
                        state_next = S_LOAD_RD;
                    end
                end
                else
                begin
                    x0_next   = rd_x;
                    scan_next = CNT_W'(scan_nx);
                    if (scan_nx + deg8 < n8)
                        rd_addr = IDX_W'(scan_nx + deg8);
                    else
                    begin
                        rd_addr    = IDX_W'(n_reg - CNT_W'(1));
                        state_next = S_LAST;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    u_next     = {3'd0, div_quo};
                    state_next = S_LOAD_RD;
                end
            end
            S_LOAD_RD:
            begin
                rd_addr    = IDX_W'(base_reg + {6'd0, k_reg});
                state_next = S_LOAD_WR;
            end
            S_LOAD_WR:
            begin
                p_next[0][k_reg] = ACC_W'(rd_x);
                p_next[1][k_reg] = ACC_W'(rd_y);
                p_next[2][k_reg] = ACC_W'(rd_z);
                if (k_reg == deg_reg)
                begin
                    lvl_next   = deg_reg;
                    idx_next   = '0;
                    state_next = S_MUL;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_LOAD_RD;
                end
            end
            S_MUL:
            begin
                // operands sign-extend to the product width
                for (int c = 0; c < 3; c++)
                    prod_next[c] = diff[c] * u_reg;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                for (int c = 0; c < 3; c++)
                    p_next[c][idx_reg] = sum[c];
                state_next = S_MUL;
                if (idx_p1 == lvl_reg)
                begin
                    idx_next = '0;
                    lvl_next = lvl_reg - 2'd1;
                    if (lvl_reg == 2'd1)
                    begin
                        ox_next    = sat16(sum[0]);
                        oy_next    = sat16(sum[1]);
                        oz_next    = sat16(sum[2]);
                        fell_next  = 1'b0;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                    idx_next = idx_p1;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign point_x   = ox_reg;
    assign point_y   = oy_reg;
    assign point_z   = oz_reg;
    assign fell_back = fell_reg;

    // checks
    `PBE_NEXT(a_accept_busy, start && !busy, busy)
    `PBE_NEXT(a_done_pulse, done, !done)
    `PBE_IMPLY(a_done_idle, done, !busy)
    `PBE_IMPLY(a_scan_in_range, state_reg == S_SCAN1, {1'b0, scan_reg} + deg8 < n8)
endmodule

@@ test/tb.sv @@
// Self-checking testbench for the piecewise Bezier evaluator.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pbe_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 200;
    localparam int ADDR_DEGREE = 0;
    localparam int ADDR_COUNT = 4;

    typedef struct {
        logic [1:0]         op;
        logic [5:0]         idx;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] cz;
        logic signed [15:0] t;
    } request_t;

    typedef struct {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] pz;
        logic               fb;
    } point_res_t;

    typedef struct {
        int         deg;
        int         cnt;
        request_t   req;
        bit         typed;
        point_res_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic start = 1'b0;
    logic busy;
    logic [1:0] opcode = '0;
    logic [5:0] slot = '0;
    logic signed [15:0] coord_x = '0;
    logic signed [15:0] coord_y = '0;
    logic signed [15:0] coord_z = '0;
    logic signed [15:0] param_t = '0;
    logic done;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic fell_back;

    piecewise_bezier_evaluator u_top (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mirror of the control point store and the two registers.
    logic signed [15:0] pts [MAX_POINTS][3];
    int unsigned cfg_degree = 3;
    int unsigned cfg_count = 0;

    point_res_t pending_pts[$];
    int errors = 0;
    int unsigned cycles = 0;
    bit no_idle = 1'b0;

    // Directed row state shared with the monitor: typed rows override the predictor.
    bit cur_typed = 1'b0;
    point_res_t cur_want;

    stim_row_t rows[$];

    task automatic report(input string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        errors++;
    endtask

    // Q4.12 multiply-back with halves rounded toward +inf (floor of v/4096 + 0.5).
    function automatic longint round_q12(input longint v);
        longint w;
        w = v + 2048;
        if (w >= 0)
            return w / 4096;
        return -((-w + 4095) / 4096);
    endfunction

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    // de Casteljau on one axis, kept at full precision until the final clamp.
    function automatic logic signed [15:0] casteljau_axis(input int first, input int deg,
                                                         input int axis, input longint t);
        longint p[4];
        for (int i = 0; i <= deg; i++)
            p[i] = pts[first + i][axis];
        for (int lvl = deg; lvl > 0; lvl--)
            for (int i = 0; i < lvl; i++)
                p[i] = p[i] + round_q12((p[i + 1] - p[i]) * t);
        return clamp16(p[0]);
    endfunction

    function automatic point_res_t segment_point(input int first, input int deg,
                                                 input longint t);
        point_res_t r;
        r.px = casteljau_axis(first, deg, 0, t);
        r.py = casteljau_axis(first, deg, 1, t);
        r.pz = casteljau_axis(first, deg, 2, t);
        r.fb = 1'b0;
        return r;
    endfunction

    function automatic point_res_t last_point(input int n);
        point_res_t r;
        r = '{16'sd0, 16'sd0, 16'sd0, 1'b1};
        if (n > 0)
        begin
            r.px = pts[n - 1][0];
            r.py = pts[n - 1][1];
            r.pz = pts[n - 1][2];
        end
        return r;
    endfunction

    // Predicts the result of one request and updates the mirrored store.
    function automatic point_res_t predict_point(input request_t q);
        point_res_t r;
        int deg;
        int n;
        longint x0;
        longint x1;
        longint u;
        r = '{16'sd0, 16'sd0, 16'sd0, 1'b0};
        deg = (cfg_degree == 0) ? 1 : int'(cfg_degree);
        n = (cfg_count > MAX_POINTS) ? MAX_POINTS : int'(cfg_count);
        if (q.op == OP_WRITE)
        begin
            pts[q.idx][0] = q.cx;
            pts[q.idx][1] = q.cy;
            pts[q.idx][2] = q.cz;
            return r;
        end
        if (q.op == OP_NONE)
            return r;
        if (n < deg + 1)
            return last_point(n);
        if (q.op == OP_EVAL_X)
        begin
            for (int i = 0; i + deg < n; i += deg)
            begin
                x0 = pts[i][0];
                x1 = pts[i + deg][0];
                if (x0 <= q.t && x1 >= q.t)
                begin
                    // zero-width segment evaluates at its start
                    u = (x1 > x0) ? ((q.t - x0) * 4096) / (x1 - x0) : 0;
                    return segment_point(i, deg, u);
                end
            end
            return last_point(n);
        end
        if (deg * int'(q.idx) + deg >= n)
            return last_point(n);
        return segment_point(deg * int'(q.idx), deg, q.t);
    endfunction

    // Results are checked before the request of the same edge is logged.
    always @(posedge clk)
    begin
        request_t q;
        point_res_t e;
        point_res_t r;
        cycles <= cycles + 1;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_pts.size() == 0)
                    report("result with nothing expected");
                else
                begin
                    e = pending_pts.pop_front();
                    if (point_x !== e.px)
                        report($sformatf("point_x %0d, want %0d", point_x, e.px));
                    if (point_y !== e.py)
                        report($sformatf("point_y %0d, want %0d", point_y, e.py));
                    if (point_z !== e.pz)
                        report($sformatf("point_z %0d, want %0d", point_z, e.pz));
                    if (fell_back !== e.fb)
                        report($sformatf("fell_back %0b, want %0b", fell_back, e.fb));
                end
            end
            if (start && !busy)
            begin
                q = '{opcode, slot, coord_x, coord_y, coord_z, param_t};
                r = predict_point(q);
                pending_pts.insert(pending_pts.size(), cur_typed ? cur_want : r);
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Drive one request from a falling edge and hold it until taken.
    task automatic send_request(input request_t q, input bit typed, input point_res_t want);
        int gap;
        cur_typed = typed;
        cur_want = want;
        opcode = q.op;
        slot = q.idx;
        coord_x = q.cx;
        coord_y = q.cy;
        coord_z = q.cz;
        param_t = q.t;
        start = 1'b1;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        @(negedge clk);
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            start = 1'b0;
            cur_typed = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_plain(input request_t q);
        send_request(q, 1'b0, '{16'sd0, 16'sd0, 16'sd0, 1'b0});
    endtask

    // Let every outstanding request finish before touching registers.
    task automatic drain;
        start = 1'b0;
        cur_typed = 1'b0;
        while (pending_pts.size() != 0 || busy)
            @(negedge clk);
    endtask

    task automatic reg_access(input int addr, input int unsigned value, input int width);
        logic [31:0] got;
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr[2:0];
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        if (addr == ADDR_DEGREE)
            cfg_degree = value & 32'h3;
        else
            cfg_count = value & 32'h7F;
        // read back
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        if ((got & ((32'd1 << width) - 1)) !== (value & ((32'd1 << width) - 1)))
            report($sformatf("register %0d reads %0h, want %0h", addr, got, value));
    endtask

    task automatic set_config(input int deg, input int cnt);
        drain();
        reg_access(ADDR_DEGREE, deg, 2);
        reg_access(ADDR_COUNT, cnt, 7);
    endtask

    task automatic add_row(input int deg, input int cnt, input logic [1:0] op,
                           input logic [5:0] idx, input logic [15:0] cx,
                           input logic [15:0] cy, input logic [15:0] cz,
                           input logic [15:0] t, input bit typed,
                           input logic [15:0] ex, input logic [15:0] ey,
                           input logic [15:0] ez, input logic efb);
        stim_row_t s;
        s.deg = deg;
        s.cnt = cnt;
        s.req = '{op, idx, cx, cy, cz, t};
        s.typed = typed;
        s.want = '{ex, ey, ez, efb};
        rows.insert(rows.size(), s);
    endtask

    function automatic logic signed [15:0] rand16;
        return 16'($urandom);
    endfunction

    // Write a non-decreasing x run over the first cnt points (at most 64); y and z random.
    task automatic write_curve(input int cnt);
        int x;
        request_t q;
        x = $urandom_range(0, 20000) - 32768;
        for (int i = 0; i < cnt && i < MAX_POINTS; i++)
        begin
            q = '{OP_WRITE, i[5:0], x[15:0], rand16(), rand16(), rand16()};
            send_plain(q);
            if ($urandom_range(0, 9) != 0)
                x = x + $urandom_range(1, 700);
        end
    endtask

    function automatic request_t random_request(input int deg, input int cnt);
        request_t q;
        int n;
        int pick;
        int lo;
        int hi;
        n = (cnt > MAX_POINTS) ? MAX_POINTS : cnt;
        q = '{OP_EVAL_X, 6'($urandom), rand16(), rand16(), rand16(), rand16()};
        pick = $urandom_range(0, 99);
        if (pick < 12)
            q.op = OP_WRITE;
        else if (pick < 16)
            q.op = OP_NONE;
        else if (pick < 60)
        begin
            q.op = OP_EVAL_X;
            // mostly inside the span of the stored curve
            if (n > 0 && $urandom_range(0, 4) != 0)
            begin
                lo = pts[0][0];
                hi = pts[n - 1][0];
                if (hi > lo)
                    q.t = 16'($urandom_range(0, hi - lo) + lo);
                else
                    q.t = 16'(lo);
            end
        end
        else
        begin
            q.op = OP_EVAL_SEG;
            if ($urandom_range(0, 4) != 0)
            begin
                q.idx = 6'($urandom_range(0, n / (deg == 0 ? 1 : deg)));
                q.t = 16'($urandom_range(0, 4096));
            end
        end
        return q;
    endfunction

    initial
    begin
        int settings_deg[$];
        int settings_cnt[$];
        int deg;
        int cnt;
        int items;
        request_t q;

        // count 0 straight after reset, then the write that seeds point 63
        add_row(3, 0, OP_EVAL_X, 0, 0, 0, 0, 16'h0000, 1, 0, 0, 0, 1);
        add_row(3, 0, OP_EVAL_SEG, 0, 0, 0, 0, 16'h0800, 1, 0, 0, 0, 1);
        add_row(3, 0, OP_NONE, 6'h3F, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0, 0, 0, 0);
        add_row(3, 0, OP_WRITE, 63, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h7FFF, 1, 0, 0, 0, 0);
        // the rest run after points 0..62 are written
        add_row(3, 64, OP_EVAL_SEG, 0, 0, 0, 0, 16'h0000, 0, 0, 0, 0, 0);
        add_row(3, 64, OP_EVAL_SEG, 1, 0, 0, 0, 16'h7FFF, 0, 0, 0, 0, 0);
        add_row(3, 64, OP_EVAL_SEG, 2, 0, 0, 0, 16'h8000, 0, 0, 0, 0, 0);
        add_row(3, 64, OP_EVAL_SEG, 21, 0, 0, 0, 16'h0800, 1, 16'h7FFF, 16'h8000, 16'hFFFF, 1);
        add_row(3, 64, OP_EVAL_SEG, 63, 0, 0, 0, 16'h1000, 1, 16'h7FFF, 16'h8000, 16'hFFFF, 1);
        add_row(3, 64, OP_WRITE, 0, 16'h0000, 16'h1000, 16'hF000, 0, 1, 0, 0, 0, 0);
        add_row(3, 64, OP_WRITE, 3, 16'h0000, 16'h7FFF, 16'h8000, 0, 1, 0, 0, 0, 0);
        add_row(3, 64, OP_EVAL_X, 0, 0, 0, 0, 16'h0000, 0, 0, 0, 0, 0);
        add_row(3, 64, OP_EVAL_X, 0, 0, 0, 0, 16'h7FFF, 0, 0, 0, 0, 0);
        add_row(3, 64, OP_EVAL_X, 0, 0, 0, 0, 16'h8000, 0, 0, 0, 0, 0);
        add_row(0, 64, OP_EVAL_SEG, 5, 0, 0, 0, 16'h0800, 0, 0, 0, 0, 0);
        add_row(1, 1, OP_EVAL_X, 0, 0, 0, 0, 16'h0000, 1, 16'h0000, 16'h1000, 16'hF000, 1);
        add_row(2, 127, OP_EVAL_SEG, 31, 0, 0, 0, 0, 1, 16'h7FFF, 16'h8000, 16'hFFFF, 1);
        add_row(2, 127, OP_EVAL_X, 0, 0, 0, 0, 16'h8000, 0, 0, 0, 0, 0);
        add_row(1, 2, OP_EVAL_SEG, 0, 0, 0, 0, 16'h0800, 0, 0, 0, 0, 0);
        add_row(1, 2, OP_WRITE, 62, 16'h8000, 16'h7FFF, 16'h0001, 0, 1, 0, 0, 0, 0);
        add_row(1, 2, OP_EVAL_SEG, 1, 0, 0, 0, 16'h0000, 0, 0, 0, 0, 0);

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int k = 0; k < rows.size(); k++)
        begin
            if (k == 4)
            begin
                // every point except 63 gets a value before anything reads it
                for (int s = 0; s < MAX_POINTS - 1; s++)
                begin
                    q = '{OP_WRITE, s[5:0], rand16(), rand16(), rand16(), rand16()};
                    send_plain(q);
                end
            end
            if (rows[k].deg != cfg_degree || rows[k].cnt != cfg_count)
                set_config(rows[k].deg, rows[k].cnt);
            send_request(rows[k].req, rows[k].typed, rows[k].want);
        end

        // random phases across register settings, extremes included
        settings_deg = '{1, 3, 2, 0, 3, 1, 2, 3, 1, 2, 3, 0, 2, 1};
        settings_cnt = '{64, 64, 0, 2, 127, 1, 65, 4, 16, 7, 31, 64, 3, 40};
        foreach (settings_deg[p])
        begin
            deg = settings_deg[p];
            cnt = settings_cnt[p];
            set_config(deg, cnt);
            no_idle = (p % 4 == 1);
            if ($urandom_range(0, 3) != 0)
                write_curve(cnt);
            items = 75;
            for (int i = 0; i < items; i++)
                send_plain(random_request(deg, cnt));
        end

        drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0 && pending_pts.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/pbe_pkg.sv
rtl/core/pbe_table.sv
rtl/core/pbe_div.sv
rtl/core/piecewise_bezier_evaluator.sv
test/tb.sv
